// ===== sv/nec_ir_frame_decoder_macros.svh =====
// ============================================================================
// NEC IR frame decoder assertion macros
// Clocked property checks used by the decoder RTL.
// ============================================================================
`ifndef NEC_IR_FRAME_DECODER_MACROS_SVH
`define NEC_IR_FRAME_DECODER_MACROS_SVH

`ifndef ASSERT_OFF
// Check a property on every rising clock edge while reset is released
`define NEC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check a property on every rising clock edge, reset included
`define NEC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define NEC_ASSERT(lbl, clk, rst_n, prop, msg)
`define NEC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== sv/nec_ir_pkg.sv =====
// ============================================================================
// NEC IR decoder package
// Types, pulse timing limits and register indexes of the NEC frame decoder.
// ============================================================================
package nec_ir_pkg;

    // Event queue geometry
    localparam int QUEUE_DEPTH = 8;
    localparam int Q_PTR_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    typedef logic [Q_PTR_W-1:0] t_qptr;

    localparam t_qptr Q_LAST = t_qptr'(QUEUE_DEPTH - 1);

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_ENABLE      = 2'd0,
        CFG_IDLE_GAP    = 2'd1,
        CFG_REP_WINDOW  = 2'd2,
        CFG_ADDR_WORD   = 2'd3
    } t_cfg_idx;

    // Register reset values
    localparam logic [7:0]  IDLE_GAP_RST   = 8'd15;
    localparam logic [15:0] REP_WINDOW_RST = 16'd180;
    localparam logic [15:0] ADDR_WORD_RST  = 16'hFF00;

    // Input command codes
    localparam logic CMD_EDGE = 1'b0;
    localparam logic CMD_POLL = 1'b1;

    // Pulse width limits in microseconds
    localparam logic [15:0] HDR_MARK_MIN  = 16'd8000;
    localparam logic [15:0] HDR_MARK_MAX  = 16'd10000;
    localparam logic [15:0] HDR_SPACE_MIN = 16'd3500;
    localparam logic [15:0] HDR_SPACE_MAX = 16'd5500;
    localparam logic [15:0] REP_SPACE_MIN = 16'd1800;
    localparam logic [15:0] REP_SPACE_MAX = 16'd2800;
    localparam logic [15:0] MARK_MIN      = 16'd350;
    localparam logic [15:0] MARK_MAX      = 16'd800;
    localparam logic [15:0] ONE_MIN       = 16'd1200;
    localparam logic [15:0] ONE_MAX       = 16'd2100;
    localparam logic [15:0] ZERO_MIN      = 16'd350;
    localparam logic [15:0] ZERO_MAX      = 16'd900;

    localparam logic [5:0]  FRAME_BITS    = 6'd32;
    localparam logic [7:0]  CMD_CHECK     = 8'hFF;

    // Frame walker states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HDR_MARK,
        ST_HDR_SPACE,
        ST_BIT_MARK,
        ST_BIT_SPACE,
        ST_STOP,
        ST_REP_STOP
    } t_state;

    // One queued event
    typedef struct packed {
        logic [7:0]  code;
        logic        rep;
        logic [31:0] time_ms;
    } t_qentry;

endpackage

// ===== sv/nec_ir_frame_decoder.sv =====
// ============================================================================
// NEC IR frame decoder
// Walks NEC frames from receiver edges, queues decoded commands in an
// on-chip event memory and pops them on poll requests.
// ============================================================================
//
//  channel   direction  handshake                   payload
//  -------   ---------  --------------------------  -------------------------
//  input     in         i_in_valid / o_in_ready     i_cmd, i_level_high,
//                                                   i_tick_count, i_now_ms
//  output    out        o_out_valid / i_out_ready   o_event_valid, o_key_code,
//                                                   o_is_repeat,
//                                                   o_event_time_ms,
//                                                   o_error_count
//  config    in         i_cfg_we                    i_cfg_index, i_cfg_data
//
//  One request per cycle while o_in_ready is high; its result passes the read
//  stage (event memory read) and then leaves the output register.
//  The edge decode is a set of combinational compares on the frame state.
//  Reset is synchronous; the event memory needs no clearing pass.
//  With the output register and the read stage both full and i_out_ready low,
//  o_in_ready drops until the output is taken.
`include "nec_ir_frame_decoder_macros.svh"

module nec_ir_frame_decoder
    import nec_ir_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    // request channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_cmd,
    input  logic        i_level_high,
    input  logic [15:0] i_tick_count,
    input  logic [31:0] i_now_ms,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_event_valid,
    output logic [7:0]  o_key_code,
    output logic        o_is_repeat,
    output logic [31:0] o_event_time_ms,
    output logic [31:0] o_error_count
);

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    logic        r_enable;
    logic [7:0]  r_idle_gap;
    logic [15:0] r_rep_window;
    logic [15:0] r_addr_word;

    t_state      r_state, n_state;
    logic [15:0] r_prev_tick;
    logic [31:0] r_prev_edge_ms;
    logic [31:0] r_shift, n_shift;
    logic [5:0]  r_bitcnt, n_bitcnt;
    logic [7:0]  r_held_code, n_held_code;
    logic [31:0] r_held_time, n_held_time;
    logic        r_repeat_ok, n_repeat_ok;
    t_qptr       r_wp, r_rp;
    logic [31:0] r_err, n_err;

    t_qentry     r_queue [QUEUE_DEPTH];
    t_qentry     r_rd;

    logic        r_s1_vld;
    logic        r_s1_hit;
    logic [31:0] r_s1_err;

    logic        r_out_vld;
    logic        r_out_hit;
    t_qentry     r_out_entry;
    logic [31:0] r_out_err;

    // ------------------------------------------------------------------
    // Handshake
    // ------------------------------------------------------------------
    logic w_out_adv;
    logic w_s1_adv;
    logic w_accept;
    logic w_edge;
    logic w_poll;
    logic w_poll_hit;

    assign w_out_adv  = !r_out_vld || i_out_ready;
    assign w_s1_adv   = r_s1_vld && w_out_adv;
    assign o_in_ready = !r_s1_vld || w_out_adv;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_edge     = w_accept && (i_cmd == CMD_EDGE) && r_enable;
    assign w_poll     = w_accept && (i_cmd == CMD_POLL);
    assign w_poll_hit = w_poll && (r_rp != r_wp);

    // ------------------------------------------------------------------
    // Pulse measurement and range checks
    // ------------------------------------------------------------------
    logic [15:0] w_width;
    logic        w_gap;
    logic        w_abandon;
    t_state      w_st;
    logic        w_hdr_mark, w_hdr_space, w_rep_space;
    logic        w_mark, w_one, w_zero;
    logic        w_frame_good;
    logic        w_rep_live;
    logic [5:0]  w_bitcnt_inc;

    assign w_width      = i_tick_count - r_prev_tick;
    assign w_gap        = (i_now_ms - r_prev_edge_ms) > {24'd0, r_idle_gap};
    assign w_abandon    = w_gap && (r_state != ST_IDLE);
    assign w_st         = w_gap ? ST_IDLE : r_state;
    assign w_hdr_mark   = w_width inside {[HDR_MARK_MIN:HDR_MARK_MAX]};
    assign w_hdr_space  = w_width inside {[HDR_SPACE_MIN:HDR_SPACE_MAX]};
    assign w_rep_space  = w_width inside {[REP_SPACE_MIN:REP_SPACE_MAX]};
    assign w_mark       = w_width inside {[MARK_MIN:MARK_MAX]};
    assign w_one        = w_width inside {[ONE_MIN:ONE_MAX]};
    assign w_zero       = w_width inside {[ZERO_MIN:ZERO_MAX]};
    assign w_frame_good = (r_shift[15:0] == r_addr_word) &&
                          ((r_shift[23:16] ^ r_shift[31:24]) == CMD_CHECK);
    assign w_rep_live   = r_repeat_ok &&
                          ((i_now_ms - r_held_time) <= {16'd0, r_rep_window});
    assign w_bitcnt_inc = r_bitcnt + 6'd1;

    // Judge the pulse that ends at this edge
    logic w_ok;

    always_comb begin
        case (w_st)
            ST_IDLE:      w_ok = 1'b1;
            ST_HDR_MARK:  w_ok = i_level_high && w_hdr_mark;
            ST_HDR_SPACE: w_ok = !i_level_high && (w_hdr_space || w_rep_space);
            ST_BIT_MARK:  w_ok = i_level_high && w_mark;
            ST_BIT_SPACE: w_ok = !i_level_high && (w_one || w_zero);
            ST_STOP:      w_ok = i_level_high && w_mark && w_frame_good;
            ST_REP_STOP:  w_ok = i_level_high && w_mark;
            default:      w_ok = 1'b0;
        endcase
    end

    // ------------------------------------------------------------------
    // Frame walker: next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        if (w_edge) begin
            if (!w_ok) begin
                n_state = i_level_high ? ST_IDLE : ST_HDR_MARK;
            end else begin
                case (w_st)
                    ST_IDLE:      n_state = i_level_high ? ST_IDLE : ST_HDR_MARK;
                    ST_HDR_MARK:  n_state = ST_HDR_SPACE;
                    ST_HDR_SPACE: n_state = w_hdr_space ? ST_BIT_MARK : ST_REP_STOP;
                    ST_BIT_MARK:  n_state = ST_BIT_SPACE;
                    ST_BIT_SPACE: n_state = (w_bitcnt_inc == FRAME_BITS) ? ST_STOP
                                                                           : ST_BIT_MARK;
                    ST_STOP:      n_state = ST_IDLE;
                    ST_REP_STOP:  n_state = ST_IDLE;
                    default:      n_state = ST_IDLE;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Frame walker: data path actions
    // ------------------------------------------------------------------
    logic    w_push;
    t_qentry w_push_entry;
    t_qptr   w_wp_next;
    logic    w_full;
    logic    w_store;

    assign w_wp_next = (r_wp == Q_LAST) ? '0 : r_wp + t_qptr'(1);
    assign w_full    = (w_wp_next == r_rp);
    assign w_store   = w_push && !w_full;

    always_comb begin
        n_shift      = r_shift;
        n_bitcnt     = r_bitcnt;
        n_held_code  = r_held_code;
        n_held_time  = r_held_time;
        n_repeat_ok  = r_repeat_ok;
        w_push       = 1'b0;
        w_push_entry = '{code: r_held_code, rep: 1'b1, time_ms: i_now_ms};
        if (w_edge) begin
            if (w_abandon) begin
                n_repeat_ok = 1'b0;
            end
            if (!w_ok) begin
                n_repeat_ok = 1'b0;
            end else begin
                case (w_st)
                    ST_HDR_SPACE: begin
                        if (w_hdr_space) begin
                            n_shift  = '0;
                            n_bitcnt = '0;
                        end
                    end
                    ST_BIT_SPACE: begin
                        if (w_one) begin
                            n_shift = r_shift | (32'd1 << r_bitcnt[4:0]);
                        end
                        n_bitcnt = w_bitcnt_inc;
                    end
                    ST_STOP: begin
                        n_held_code  = r_shift[23:16];
                        n_held_time  = i_now_ms;
                        n_repeat_ok  = 1'b1;
                        w_push       = 1'b1;
                        w_push_entry = '{code: r_shift[23:16], rep: 1'b0,
                                         time_ms: i_now_ms};
                    end
                    ST_REP_STOP: begin
                        if (w_rep_live) begin
                            w_push      = 1'b1;
                            n_held_time = i_now_ms;
                        end else begin
                            n_repeat_ok = 1'b0;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // Bump the error total: abandoned frame, bad pulse or dropped event
    always_comb begin
        n_err = r_err;
        if (w_edge && (w_abandon || !w_ok || (w_push && w_full))) begin
            n_err = r_err + 32'd1;
        end
    end

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable     <= 1'b0;
            r_idle_gap   <= IDLE_GAP_RST;
            r_rep_window <= REP_WINDOW_RST;
            r_addr_word  <= ADDR_WORD_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_ENABLE:     r_enable     <= i_cfg_data[0];
                CFG_IDLE_GAP:   r_idle_gap   <= i_cfg_data[7:0];
                CFG_REP_WINDOW: r_rep_window <= i_cfg_data;
                CFG_ADDR_WORD:  r_addr_word  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Decoder state registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_prev_tick    <= '0;
            r_prev_edge_ms <= '0;
            r_shift        <= '0;
            r_bitcnt       <= '0;
            r_held_code    <= '0;
            r_held_time    <= '0;
            r_repeat_ok    <= 1'b0;
            r_err          <= '0;
        end else begin
            r_state     <= n_state;
            r_shift     <= n_shift;
            r_bitcnt    <= n_bitcnt;
            r_held_code <= n_held_code;
            r_held_time <= n_held_time;
            r_repeat_ok <= n_repeat_ok;
            r_err       <= n_err;
            if (w_edge) begin
                r_prev_tick    <= i_tick_count;
                r_prev_edge_ms <= i_now_ms;
            end
        end
    end

    // ------------------------------------------------------------------
    // Event queue pointers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
        end else begin
            if (w_store) begin
                r_wp <= w_wp_next;
            end
            if (w_poll_hit) begin
                r_rp <= (r_rp == Q_LAST) ? '0 : r_rp + t_qptr'(1);
            end
        end
    end

    // Write a new event into the queue memory
    always_ff @(posedge i_clk) begin
        if (w_store) begin
            r_queue[r_wp] <= w_push_entry;
        end
    end

    // Read the oldest event; an entry is written in memory when the write pointer moves past it
    always_ff @(posedge i_clk) begin
        if (w_poll_hit) begin
            r_rd <= r_queue[r_rp];
        end
    end

    // ------------------------------------------------------------------
    // Read stage: hold hit flag and error total alongside memory read
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (w_accept) begin
            r_s1_vld <= 1'b1;
        end else if (w_s1_adv) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_hit <= w_poll_hit;
            r_s1_err <= n_err;
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_out_adv) begin
            r_out_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_adv) begin
            r_out_hit   <= r_s1_hit;
            r_out_entry <= r_s1_hit ? r_rd : '0;
            r_out_err   <= r_s1_err;
        end
    end

    assign o_out_valid     = r_out_vld;
    assign o_event_valid   = r_out_hit;
    assign o_key_code      = r_out_entry.code;
    assign o_is_repeat     = r_out_entry.rep;
    assign o_event_time_ms = r_out_entry.time_ms;
    assign o_error_count   = r_out_err;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `NEC_ASSERT(a_err_step, i_clk, i_rst_n,
        1'b1 |=> (r_err == $past(r_err) || r_err == $past(r_err) + 32'd1),
        "error total moved by more than one")
    `NEC_ASSERT(a_state_hold, i_clk, i_rst_n,
        !w_edge |=> $stable(r_state),
        "frame state changed without an edge")
    `NEC_ASSERT(a_wp_hold, i_clk, i_rst_n,
        !w_edge |=> $stable(r_wp),
        "queue write pointer moved without an edge")
    `NEC_ASSERT(a_hit_stage, i_clk, i_rst_n,
        w_poll_hit |=> (r_s1_vld && r_s1_hit),
        "poll hit lost before read stage")

endmodule

// ===== tb/nec_ir_frame_decoder_test.sv =====
// ============================================================================
// NEC IR frame decoder testbench
// Sends edge and poll requests, predicts every result with an untimed model
// of the frame walker and event queue, and checks each result field in order.
// A short table of directed requests comes first. Random NEC frames, repeats,
// corrupt and truncated frames and line noise follow, under several register
// settings and several sender and receiver idling patterns.
// ============================================================================
module nec_ir_frame_decoder_test;
    import nec_ir_pkg::*;

    // Pulse width limits in microseconds
    localparam int HDR_MARK_LO   = 8000;
    localparam int HDR_MARK_HI   = 10000;
    localparam int LEAD_SPACE_LO = 3500;
    localparam int LEAD_SPACE_HI = 5500;
    localparam int REP_SPACE_LO  = 1800;
    localparam int REP_SPACE_HI  = 2800;
    localparam int MARK_LO       = 350;
    localparam int MARK_HI       = 800;
    localparam int ONE_LO        = 1200;
    localparam int ONE_HI        = 2100;
    localparam int ZERO_LO       = 350;
    localparam int ZERO_HI       = 900;

    localparam int SETTLE_CYCLES = 6;

    typedef enum int {
        PACE_FREE,
        PACE_SENDER,
        PACE_RECEIVER,
        PACE_BOTH
    } t_pace;

    typedef struct packed {
        logic        ev;
        logic [7:0]  key;
        logic        rep;
        logic [31:0] ev_ms;
        logic [31:0] errs;
    } t_poll_result;

    typedef struct packed {
        logic        en_before;
        logic        cmd;
        logic        level;
        logic [15:0] tick;
        logic [31:0] now_ms;
        logic        known;
        logic [31:0] known_errs;
    } t_probe_row;

    logic        i_clk;
    logic        i_rst_n         = 1'b0;
    logic        i_cfg_we        = 1'b0;
    logic [1:0]  i_cfg_index     = '0;
    logic [15:0] i_cfg_data      = '0;
    logic        i_in_valid      = 1'b0;
    logic        o_in_ready;
    logic        i_cmd           = 1'b0;
    logic        i_level_high    = 1'b0;
    logic [15:0] i_tick_count    = '0;
    logic [31:0] i_now_ms        = '0;
    logic        o_out_valid;
    logic        i_out_ready     = 1'b0;
    logic        o_event_valid;
    logic [7:0]  o_key_code;
    logic        o_is_repeat;
    logic [31:0] o_event_time_ms;
    logic [31:0] o_error_count;

    nec_ir_frame_decoder u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_cmd           (i_cmd),
        .i_level_high    (i_level_high),
        .i_tick_count    (i_tick_count),
        .i_now_ms        (i_now_ms),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_event_valid   (o_event_valid),
        .o_key_code      (o_key_code),
        .o_is_repeat     (o_is_repeat),
        .o_event_time_ms (o_event_time_ms),
        .o_error_count   (o_error_count)
    );

    // Register mirror
    logic        cfg_enable     = 1'b0;
    logic [7:0]  cfg_idle_gap   = 8'd15;
    logic [15:0] cfg_rep_window = 16'd180;
    logic [15:0] cfg_addr_word  = 16'hFF00;

    // Decoder mirror
    t_state      walk_state     = ST_IDLE;
    logic [15:0] last_tick      = '0;
    logic [31:0] prev_edge_time = '0;
    logic [31:0] frame_bits     = '0;
    logic [5:0]  frame_bit_cnt  = '0;
    logic [7:0]  held_key       = '0;
    logic [31:0] held_ms        = '0;
    logic        repeat_armed   = 1'b0;
    t_qentry     event_store [QUEUE_DEPTH];
    t_qptr       wr_slot        = '0;
    t_qptr       rd_slot        = '0;
    logic [31:0] error_total    = '0;

    t_poll_result expected_results [$];

    int fail_count         = 0;
    int accepted_items     = 0;
    int results_checked    = 0;
    int events_popped      = 0;
    int repeats_popped     = 0;
    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int poll_limit         = 2;
    int frame_edges_left   = 0;
    logic [63:0] line_us   = 64'd0;

    // Directed requests; the first rows run with the decoder still disabled
    t_probe_row probe_table [23] = '{
        '{1'b0, CMD_POLL, 1'b0, 16'h0000, 32'h0000_0000, 1'b1, 32'd0},
        '{1'b0, CMD_EDGE, 1'b0, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 32'd0},
        '{1'b1, CMD_EDGE, 1'b0, 16'hFFF0, 32'd1,         1'b0, 32'd0},
        '{1'b0, CMD_EDGE, 1'b1, 16'h1F30, 32'd9,         1'b0, 32'd0},
        '{1'b0, CMD_EDGE, 1'b0, 16'h2637, 32'd10,        1'b1, 32'd1},
        '{1'b0, CMD_EDGE, 1'b1, 16'h4D48, 32'd20,        1'b1, 32'd2},
        '{1'b0, CMD_EDGE, 1'b0, 16'h4DAC, 32'd20,        1'b0, 32'd0},
        '{1'b0, CMD_EDGE, 1'b1, 16'h74BC, 32'd30,        1'b0, 32'd0},
        '{1'b0, CMD_EDGE, 1'b0, 16'h7FAC, 32'd33,        1'b0, 32'd0},
        '{1'b0, CMD_EDGE, 1'b1, 16'h810A, 32'd33,        1'b1, 32'd2},
        '{1'b0, CMD_POLL, 1'b1, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 32'd2},
        '{1'b0, CMD_EDGE, 1'b0, 16'h8200, 32'd40,        1'b0, 32'd0},
        '{1'b0, CMD_EDGE, 1'b1, 16'hA528, 32'd60,        1'b1, 32'd3},
        '{1'b0, CMD_EDGE, 1'b1, 16'hFFFF, 32'hFFFF_FFFF, 1'b0, 32'd0},
        '{1'b0, CMD_EDGE, 1'b0, 16'h0010, 32'd5,         1'b0, 32'd0},
        '{1'b0, CMD_EDGE, 1'b1, 16'h1F4F, 32'd13,        1'b1, 32'd4},
        '{1'b0, CMD_EDGE, 1'b0, 16'h2000, 32'd14,        1'b0, 32'd0},
        '{1'b0, CMD_EDGE, 1'b1, 16'h4327, 32'd23,        1'b0, 32'd0},
        '{1'b0, CMD_EDGE, 1'b0, 16'h58A4, 32'd28,        1'b1, 32'd5},
        '{1'b0, CMD_EDGE, 1'b1, 16'h7DC0, 32'd38,        1'b0, 32'd0},
        '{1'b0, CMD_EDGE, 1'b0, 16'h8B6C, 32'd41,        1'b0, 32'd0},
        '{1'b0, CMD_EDGE, 1'b0, 16'h8D60, 32'd41,        1'b1, 32'd6},
        '{1'b0, CMD_POLL, 1'b0, 16'h0000, 32'h0000_0000, 1'b1, 32'd6}
    };

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Hard limit on run length
    initial begin
        #(12 * 1000000);
        $display("status: fail");
        $finish;
    end

    function automatic logic in_span(logic [15:0] w, int lo, int hi);
        return (int'(w) >= lo) && (int'(w) <= hi);
    endfunction

    // Queue one event, or count an overflow when only the spare slot is left
    function automatic void queue_event(logic [7:0] key, logic is_rep, logic [31:0] ms);
        t_qptr nxt;
        nxt = (wr_slot == Q_LAST) ? t_qptr'(0) : t_qptr'(wr_slot + 1'b1);
        if (nxt == rd_slot) begin
            error_total++;
        end else begin
            event_store[wr_slot] = '{code: key, rep: is_rep, time_ms: ms};
            wr_slot = nxt;
        end
    endfunction

    // Advance the frame walker by one receiver edge
    function automatic void walk_edge(logic high, logic [15:0] tick, logic [31:0] now);
        logic [15:0] width;
        logic [31:0] gap_ms;
        logic        good;
        width  = tick - last_tick;
        gap_ms = now - prev_edge_time;
        good   = 1'b1;

        // Abandon a partial frame after a long silence
        if (gap_ms > {24'd0, cfg_idle_gap}) begin
            if (walk_state != ST_IDLE) begin
                error_total++;
                repeat_armed = 1'b0;
            end
            walk_state = ST_IDLE;
        end
        prev_edge_time = now;
        last_tick      = tick;

        case (walk_state)
            ST_IDLE: begin
                if (!high) walk_state = ST_HDR_MARK;
            end
            ST_HDR_MARK: begin
                if (high && in_span(width, HDR_MARK_LO, HDR_MARK_HI)) walk_state = ST_HDR_SPACE;
                else good = 1'b0;
            end
            ST_HDR_SPACE: begin
                if (!high && in_span(width, LEAD_SPACE_LO, LEAD_SPACE_HI)) begin
                    walk_state    = ST_BIT_MARK;
                    frame_bits    = '0;
                    frame_bit_cnt = '0;
                end else if (!high && in_span(width, REP_SPACE_LO, REP_SPACE_HI)) begin
                    walk_state = ST_REP_STOP;
                end else begin
                    good = 1'b0;
                end
            end
            ST_BIT_MARK: begin
                if (high && in_span(width, MARK_LO, MARK_HI)) walk_state = ST_BIT_SPACE;
                else good = 1'b0;
            end
            ST_BIT_SPACE: begin
                if (high || !(in_span(width, ONE_LO, ONE_HI) ||
                              in_span(width, ZERO_LO, ZERO_HI))) begin
                    good = 1'b0;
                end else begin
                    if (in_span(width, ONE_LO, ONE_HI)) frame_bits[frame_bit_cnt[4:0]] = 1'b1;
                    frame_bit_cnt = frame_bit_cnt + 6'd1;
                    walk_state    = (frame_bit_cnt == 6'd32) ? ST_STOP : ST_BIT_MARK;
                end
            end
            ST_STOP: begin
                if (high && in_span(width, MARK_LO, MARK_HI) &&
                    frame_bits[15:0] == cfg_addr_word &&
                    (frame_bits[23:16] ^ frame_bits[31:24]) == 8'hFF) begin
                    held_key     = frame_bits[23:16];
                    held_ms      = now;
                    repeat_armed = 1'b1;
                    queue_event(held_key, 1'b0, now);
                    walk_state   = ST_IDLE;
                end else begin
                    good = 1'b0;
                end
            end
            ST_REP_STOP: begin
                if (high && in_span(width, MARK_LO, MARK_HI)) begin
                    // A repeat counts only after a good code and inside the window
                    if (repeat_armed && (now - held_ms) <= {16'd0, cfg_rep_window}) begin
                        queue_event(held_key, 1'b1, now);
                        held_ms = now;
                    end else begin
                        repeat_armed = 1'b0;
                    end
                    walk_state = ST_IDLE;
                end else begin
                    good = 1'b0;
                end
            end
            default: good = 1'b0;
        endcase

        if (!good) begin
            error_total++;
            repeat_armed = 1'b0;
            walk_state   = high ? ST_IDLE : ST_HDR_MARK;
        end
    endfunction

    // Expected result of one accepted request
    function automatic t_poll_result decode_request(logic cmd, logic level,
                                                    logic [15:0] tick, logic [31:0] now);
        t_poll_result res;
        res = '0;
        if (cmd == CMD_EDGE) begin
            if (cfg_enable) walk_edge(level, tick, now);
        end else if (rd_slot != wr_slot) begin
            res.ev    = 1'b1;
            res.key   = event_store[rd_slot].code;
            res.rep   = event_store[rd_slot].rep;
            res.ev_ms = event_store[rd_slot].time_ms;
            rd_slot   = (rd_slot == Q_LAST) ? t_qptr'(0) : t_qptr'(rd_slot + 1'b1);
        end
        res.errs = error_total;
        return res;
    endfunction

    // Send one request and record its expected result once accepted
    task automatic send_request(logic req_cmd, logic req_level, logic [15:0] req_tick,
                                logic [31:0] req_now, logic known, logic [31:0] known_errs);
        t_poll_result predicted;
        t_poll_result fixed;
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_cmd        <= req_cmd;
        i_level_high <= req_level;
        i_tick_count <= req_tick;
        i_now_ms     <= req_now;
        do @(posedge i_clk); while (!o_in_ready);

        if (req_cmd == CMD_POLL || cfg_enable) accepted_items++;
        predicted = decode_request(req_cmd, req_level, req_tick, req_now);
        fixed      = '0;
        fixed.errs = known_errs;
        expected_results.push_back(known ? fixed : predicted);
    endtask

    task automatic put_register(t_cfg_idx idx, logic [15:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        case (idx)
            CFG_ENABLE:     cfg_enable     = data[0];
            CFG_IDLE_GAP:   cfg_idle_gap   = data[7:0];
            CFG_REP_WINDOW: cfg_rep_window = data;
            CFG_ADDR_WORD:  cfg_addr_word  = data;
            default: ;
        endcase
    endtask

    task automatic apply_settings(logic en, logic [7:0] gap, logic [15:0] win,
                                  logic [15:0] addr);
        put_register(CFG_ENABLE, {15'd0, en});
        put_register(CFG_IDLE_GAP, {8'd0, gap});
        put_register(CFG_REP_WINDOW, win);
        put_register(CFG_ADDR_WORD, addr);
        i_cfg_we <= 1'b0;
    endtask

    // Drop valid and wait until every expected result is back
    task automatic settle_queue();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic send_poll();
        send_request(CMD_POLL, 1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)),
                     $urandom(), 1'b0, 32'd0);
    endtask

    // Advance line time and send the edge that ends the pulse
    task automatic send_edge(logic level, int width_us);
        line_us += 64'(width_us);
        if ($urandom_range(0, 29) == 0) send_poll();
        send_request(CMD_EDGE, level, line_us[15:0], 32'(line_us / 64'd1000), 1'b0, 32'd0);
    endtask

    task automatic send_frame_edge(logic level, int width_us);
        if (frame_edges_left > 0) begin
            frame_edges_left--;
            send_edge(level, width_us);
        end
    endtask

    // Mostly in range, some exactly at the limits, rarely just outside
    function automatic int pick_pulse(int lo, int hi);
        int r;
        r = $urandom_range(0, 399);
        if (r == 0) return lo - 1;
        if (r == 1) return hi + 1;
        if (r < 22) return lo;
        if (r < 42) return hi;
        return $urandom_range(lo, hi);
    endfunction

    function automatic int pick_gap();
        if ($urandom_range(0, 9) == 0) return $urandom_range(0, 20000);
        return $urandom_range(20000, 250000);
    endfunction

    task automatic send_data_frame(logic [31:0] bits);
        send_frame_edge(1'b0, pick_gap());
        send_frame_edge(1'b1, pick_pulse(HDR_MARK_LO, HDR_MARK_HI));
        send_frame_edge(1'b0, pick_pulse(LEAD_SPACE_LO, LEAD_SPACE_HI));
        for (int b = 0; b < 32; b++) begin
            send_frame_edge(1'b1, pick_pulse(MARK_LO, MARK_HI));
            send_frame_edge(1'b0, bits[b] ? pick_pulse(ONE_LO, ONE_HI)
                                          : pick_pulse(ZERO_LO, ZERO_HI));
        end
        send_frame_edge(1'b1, pick_pulse(MARK_LO, MARK_HI));
    endtask

    task automatic send_repeat_frame();
        send_frame_edge(1'b0, pick_gap());
        send_frame_edge(1'b1, pick_pulse(HDR_MARK_LO, HDR_MARK_HI));
        send_frame_edge(1'b0, pick_pulse(REP_SPACE_LO, REP_SPACE_HI));
        send_frame_edge(1'b1, pick_pulse(MARK_LO, MARK_HI));
    endtask

    // One random stretch of line activity followed by a few polls
    task automatic run_burst();
        int         pick;
        logic [7:0] key;
        logic [7:0] flip;
        pick             = $urandom_range(0, 99);
        key              = 8'($urandom());
        flip             = 8'($urandom_range(1, 255));
        frame_edges_left = 1000;
        if (pick < 45) begin
            send_data_frame({~key, key, cfg_addr_word});
            repeat ($urandom_range(0, 3)) begin
                frame_edges_left = 1000;
                send_repeat_frame();
            end
        end else if (pick < 58) begin
            send_repeat_frame();
        end else if (pick < 66) begin
            send_data_frame({~key, key, 16'($urandom())});
        end else if (pick < 72) begin
            send_data_frame({~key ^ flip, key, cfg_addr_word});
        end else if (pick < 82) begin
            // Cut the frame short; the next frame finds the walker mid-frame
            frame_edges_left = $urandom_range(1, 67);
            send_data_frame({~key, key, cfg_addr_word});
        end else if (pick < 92) begin
            repeat ($urandom_range(1, 6)) begin
                if ($urandom_range(0, 1) == 0) begin
                    send_request(CMD_EDGE, 1'($urandom_range(0, 1)),
                                 16'($urandom_range(0, 65535)), $urandom(), 1'b0, 32'd0);
                end else begin
                    send_edge(1'($urandom_range(0, 1)), $urandom_range(0, 70000));
                end
            end
        end else begin
            repeat ($urandom_range(1, 8)) send_poll();
        end
        repeat ($urandom_range(0, poll_limit)) send_poll();
    endtask

    task automatic run_phase(logic en, logic [7:0] gap, logic [15:0] win, logic [15:0] addr,
                             t_pace pace, int target, int polls);
        int start;
        settle_queue();
        apply_settings(en, gap, win, addr);
        case (pace)
            PACE_FREE:     begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            PACE_SENDER:   begin sender_idle_pct = 88; receiver_stall_pct = 0;  end
            PACE_RECEIVER: begin sender_idle_pct = 0;  receiver_stall_pct = 88; end
            default:       begin sender_idle_pct = 22; receiver_stall_pct = 22; end
        endcase
        poll_limit = polls;
        start      = accepted_items;
        while (accepted_items - start < target) run_burst();
    endtask

    // Receiver stalls
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
    end

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            fail_count++;
            $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
        end
    endtask

    // Compare each accepted result with the oldest expectation
    always @(posedge i_clk) begin
        t_poll_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_checked++;
            if (expected_results.size() == 0) begin
                fail_count++;
                $display("%0t: unexpected result, expected none, got event_valid %b",
                         $time, o_event_valid);
            end else begin
                want = expected_results.pop_front();
                check_field("event_valid", 32'(want.ev), 32'(o_event_valid));
                check_field("key_code", 32'(want.key), 32'(o_key_code));
                check_field("is_repeat", 32'(want.rep), 32'(o_is_repeat));
                check_field("event_time_ms", want.ev_ms, o_event_time_ms);
                check_field("error_count", want.errs, o_error_count);
                if (want.ev) events_popped++;
                if (want.ev && want.rep) repeats_popped++;
            end
        end
    end

    // Stimulus
    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table
        foreach (probe_table[r]) begin
            if (probe_table[r].en_before) begin
                settle_queue();
                apply_settings(1'b1, 8'd15, 16'd180, 16'hFF00);
            end
            send_request(probe_table[r].cmd, probe_table[r].level, probe_table[r].tick,
                         probe_table[r].now_ms, probe_table[r].known,
                         probe_table[r].known_errs);
        end

        // Random phases
        run_phase(1'b1, 8'd15, 16'd180, 16'hFF00, PACE_FREE, 300, 2);
        run_phase(1'b1, 8'd255, 16'hFFFF, 16'h0000, PACE_SENDER, 300, 1);
        run_phase(1'b1, 8'd0, 16'd0, 16'hFFFF, PACE_RECEIVER, 150, 3);
        run_phase(1'b1, 8'($urandom_range(10, 60)), 16'($urandom_range(90, 260)),
                  16'($urandom()), PACE_BOTH, 300, 2);
        run_phase(1'b0, 8'd15, 16'd180, 16'hFF00, PACE_FREE, 20, 4);
        // Start just short of the millisecond wrap
        line_us = (64'd1 << 32) * 64'd1000 - 64'd2000000;
        run_phase(1'b1, 8'd20, 16'd200, 16'($urandom()), PACE_SENDER, 300, 1);
        run_phase(1'b1, 8'd15, 16'd180, 16'hFF00, PACE_RECEIVER, 150, 2);
        settle_queue();

        $display("Checked %0d results from %0d accepted requests; %0d events popped, %0d repeats.",
                 results_checked, accepted_items, events_popped, repeats_popped);
        $display("Seven phases over six register settings and four idling patterns; %s %0d.",
                 "final error total", error_total);
        if (fail_count == 0 && expected_results.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+sv
sv/nec_ir_pkg.sv
sv/nec_ir_frame_decoder.sv
tb/nec_ir_frame_decoder_test.sv
